>>> design/bfde_pkg.sv
// ----------------------------------------------------------------------------
// bfde_pkg
// Shared types and constants of the braille frame delta encoder: register
// indexes, field widths, the command passed from front to back, and the
// small helpers used on both sides.
// ----------------------------------------------------------------------------
package bfde_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int ROWS_W     = 9;
  localparam int COLS_W     = 10;
  localparam int SIZE_W     = 11;  // holds any size up to 999 plus one

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS = 2'd1;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd24;
  localparam logic [COLS_W-1:0] COLS_RESET = 10'd80;

  // three decimal digits cover every position up to 999
  localparam int BCD_W = 12;
  localparam logic [BCD_W-1:0] BCD_ONE = 12'h001;

  // byte constants of the stream
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_H     = 8'h48;  // 'H'
  localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
  localparam logic [7:0] CH_THREE = 8'h33;  // '3'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] COLOR_BASE = 8'h2F;  // '0' - 1
  localparam logic [7:0] UTF_LEAD = 8'hE2;
  localparam logic [7:0] UTF_MID  = 8'hA0;
  localparam logic [7:0] UTF_LOW  = 8'h80;

  // queue between front and back
  localparam int Q_DEPTH = 4;

  // one cell's worth of work for the back end
  typedef struct packed {
    logic                  has_frame;  // default-color escape at frame start
    logic                  has_cur;    // cursor-position escape
    logic                  has_color;  // color escape
    logic                  has_tail;   // glyph or overlay character
    logic                  tail3;      // tail is a three-byte glyph
    logic [BCD_W-1:0]      row_bcd;    // 1-based row, decimal
    logic [BCD_W-1:0]      col_bcd;    // 1-based column, decimal
    logic [3:0]            color;
    logic [2:0][7:0]       tail;
  } cmd_t;

  // decimal increment of a three-digit number
  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    if (v[3:0] != 4'd9) begin
      r[3:0] = v[3:0] + 4'd1;
    end else begin
      r[3:0] = 4'd0;
      if (v[7:4] != 4'd9) begin
        r[7:4] = v[7:4] + 4'd1;
      end else begin
        r[7:4] = 4'd0;
        r[11:8] = v[11:8] + 4'd1;
      end
    end
    return r;
  endfunction

  // significant digit count of a decimal number, 1 to 3
  function automatic logic [1:0] bcd_len(input logic [BCD_W-1:0] v);
    logic [1:0] n;
    if (v[11:8] != 4'd0) begin
      n = 2'd3;
    end else if (v[7:4] != 4'd0) begin
      n = 2'd2;
    end else begin
      n = 2'd1;
    end
    return n;
  endfunction

endpackage

>>> design/braille_frame_delta_encoder.sv
// A cell with output passes the command queue, command register and output register
// before its first byte shows. Throughput: one output byte per cycle while commands
// wait and pop drains the output register; a cell is taken whenever the queue is not
// full and has 0 to 23 bytes, sent by the single byte output port; a four-entry
// command queue separates both. Reset: sizes 24 rows by 80 columns, position top left,
// queue and output register empty; the block accepts beats right after reset.
// ----------------------------------------------------------------------------
// braille_frame_delta_encoder
// Turns raster-ordered character cells into the terminal byte stream that
// redraws only the changed cells, with cursor and color escapes.
// ----------------------------------------------------------------------------
module braille_frame_delta_encoder #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       new_stencil,
  input  logic [3:0]                       new_color,
  input  logic [7:0]                       new_text,
  input  logic [7:0]                       old_stencil,
  input  logic [3:0]                       old_color,
  input  logic [7:0]                       old_text,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       out_byte,
  output logic                             run_last,
  input  logic                             wr_en,
  input  logic [bfde_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bfde_pkg::CFG_DATA_W-1:0]  wr_data
);
  import bfde_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  logic q_rd;
  logic q_valid;
  cmd_t q_cmd;

  assign accept = push && !full;

  // front: classify cells
  bfde_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .new_stencil (new_stencil),
    .new_color   (new_color),
    .new_text    (new_text),
    .old_stencil (old_stencil),
    .old_color   (old_color),
    .old_text    (old_text),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  // command queue
  bfde_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (cmd_push),
    .wr_cmd   (cmd),
    .full     (full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  // back: byte sequencer
  bfde_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .run_last (run_last)
  );

endmodule

>>> design/bfde_queue.sv
// ----------------------------------------------------------------------------
// bfde_queue
// Small command queue between the front and the back end.
// ----------------------------------------------------------------------------
module bfde_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  bfde_pkg::cmd_t  wr_cmd,
  output logic            full,
  input  logic            rd,
  output logic            rd_valid,
  output bfde_pkg::cmd_t  rd_cmd
);
  import bfde_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/bfde_front.sv
// ----------------------------------------------------------------------------
// bfde_front
// Accepts cells, tracks position, cursor gap and terminal color, and turns
// each cell that needs output into one command for the back end.
// ----------------------------------------------------------------------------
module bfde_front #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [7:0]                       new_stencil,
  input  logic [3:0]                       new_color,
  input  logic [7:0]                       new_text,
  input  logic [7:0]                       old_stencil,
  input  logic [3:0]                       old_color,
  input  logic [7:0]                       old_text,
  input  logic                             wr_en,
  input  logic [bfde_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bfde_pkg::CFG_DATA_W-1:0]  wr_data,
  output logic                             cmd_push,
  output bfde_pkg::cmd_t                   cmd
);
  import bfde_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [ROWS_W-1:0] screen_rows;
  logic [COLS_W-1:0] screen_cols;
  logic [RW-1:0]     row_index;
  logic [CW-1:0]     col_index;
  logic [BCD_W-1:0]  row_bcd;
  logic [BCD_W-1:0]  col_bcd;
  logic              gap_pending;
  logic [3:0]        active_color;

  logic [SIZE_W-1:0] nrows;
  logic [SIZE_W-1:0] ncols;
  logic              frame;
  logic              gap;
  logic [3:0]        act;
  logic              overlaid;
  logic              skip;
  logic [7:0]        glyph;
  logic              col_wrap;
  logic              row_wrap;

  // sizes clamped to the supported range
  always_comb begin
    if (screen_rows == '0) begin
      nrows = SIZE_W'(1);
    end else if (SIZE_W'(screen_rows) > SIZE_W'(MAX_ROWS)) begin
      nrows = SIZE_W'(MAX_ROWS);
    end else begin
      nrows = SIZE_W'(screen_rows);
    end
    if (screen_cols == '0) begin
      ncols = SIZE_W'(1);
    end else if (SIZE_W'(screen_cols) > SIZE_W'(MAX_COLS)) begin
      ncols = SIZE_W'(MAX_COLS);
    end else begin
      ncols = SIZE_W'(screen_cols);
    end
  end

  assign col_wrap = (SIZE_W'(col_index) + SIZE_W'(1)) >= ncols;
  assign row_wrap = (SIZE_W'(row_index) + SIZE_W'(1)) >= nrows;

  // classify the cell
  assign frame    = (row_index == '0) && (col_index == '0);
  assign gap      = frame || gap_pending;
  assign act      = frame ? 4'd0 : active_color;
  assign overlaid = (new_text != 8'd0);
  assign skip     = (new_text == old_text) &&
                    (overlaid || ((new_stencil == old_stencil) && (new_color == old_color)));
  assign glyph    = {new_stencil[7], new_stencil[3], new_stencil[6:4], new_stencil[2:0]};

  // build the command
  always_comb begin
    cmd.has_frame = frame;
    cmd.has_cur   = !skip && gap;
    cmd.has_tail  = !skip;
    cmd.tail3     = !overlaid;
    cmd.row_bcd   = row_bcd;
    cmd.col_bcd   = col_bcd;
    if (overlaid) begin
      cmd.has_color = !skip && (act != 4'd0);
      cmd.color     = 4'd0;
      cmd.tail[0]   = new_text;
      cmd.tail[1]   = 8'd0;
      cmd.tail[2]   = 8'd0;
    end else begin
      cmd.has_color = !skip && (new_color != act);
      cmd.color     = new_color;
      cmd.tail[0]   = UTF_LEAD;
      cmd.tail[1]   = UTF_MID | {6'd0, glyph[7:6]};
      cmd.tail[2]   = UTF_LOW | {2'd0, glyph[5:0]};
    end
  end

  assign cmd_push = accept && (frame || !skip);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows <= ROWS_RESET;
      screen_cols <= COLS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SCREEN_ROWS: screen_rows <= wr_data[ROWS_W-1:0];
        REG_SCREEN_COLS: screen_cols <= wr_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // position, gap and color tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= '0;
      col_index    <= '0;
      row_bcd      <= BCD_ONE;
      col_bcd      <= BCD_ONE;
      gap_pending  <= 1'b1;
      active_color <= 4'd0;
    end else if (accept) begin
      gap_pending <= skip;
      if (skip) begin
        active_color <= act;
      end else begin
        active_color <= overlaid ? 4'd0 : new_color;
      end
      if (col_wrap) begin
        col_index <= '0;
        col_bcd   <= BCD_ONE;
        if (row_wrap) begin
          row_index <= '0;
          row_bcd   <= BCD_ONE;
        end else begin
          row_index <= row_index + RW'(1);
          row_bcd   <= bcd_inc(row_bcd);
        end
      end else begin
        col_index <= col_index + CW'(1);
        col_bcd   <= bcd_inc(col_bcd);
      end
    end
  end

endmodule

>>> design/bfde_back.sv
// ----------------------------------------------------------------------------
// bfde_back
// Walks one command at a time through its escape and glyph sections and
// sends one byte per beat into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module bfde_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  bfde_pkg::cmd_t  q_cmd,
  output logic            q_rd,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte,
  output logic            run_last
);
  import bfde_pkg::*;

  typedef enum logic [1:0] {
    PH_FRAME,
    PH_CUR,
    PH_COLOR,
    PH_TAIL
  } phase_t;

  cmd_t       cur;
  logic       busy;
  phase_t     phase;
  logic [3:0] idx;
  logic       ovalid;

  logic       advance;
  logic       sec_last;
  logic       cmd_last;
  logic [7:0] byte_now;
  phase_t     phase_after;
  phase_t     phase_first;
  logic [1:0] nr;
  logic [1:0] nc;
  logic [3:0] row_end;
  logic [3:0] semi_pos;
  logic [3:0] col_end;
  logic [3:0] k;
  logic [1:0] dpos;
  logic [3:0] digit;

  assign empty   = !ovalid;
  assign advance = busy && (!ovalid || pop);
  assign q_rd    = q_valid && (!busy || (advance && cmd_last));

  // cursor escape layout
  assign nr       = bcd_len(cur.row_bcd);
  assign nc       = bcd_len(cur.col_bcd);
  assign row_end  = 4'd2 + {2'd0, nr};
  assign semi_pos = row_end;
  assign col_end  = semi_pos + 4'd1 + {2'd0, nc};

  // digit picked from the row or column number
  always_comb begin
    if (idx < row_end) begin
      k    = idx - 4'd2;
      dpos = nr - 2'd1 - k[1:0];
      case (dpos)
        2'd0:    digit = cur.row_bcd[3:0];
        2'd1:    digit = cur.row_bcd[7:4];
        default: digit = cur.row_bcd[11:8];
      endcase
    end else begin
      k    = idx - semi_pos - 4'd1;
      dpos = nc - 2'd1 - k[1:0];
      case (dpos)
        2'd0:    digit = cur.col_bcd[3:0];
        2'd1:    digit = cur.col_bcd[7:4];
        default: digit = cur.col_bcd[11:8];
      endcase
    end
  end

  // byte of the current section
  always_comb begin
    byte_now = CH_ESC;
    sec_last = 1'b0;
    case (phase)
      PH_FRAME, PH_COLOR: begin
        case (idx)
          4'd0:    byte_now = CH_ESC;
          4'd1:    byte_now = CH_LBRK;
          4'd2:    byte_now = CH_THREE;
          4'd3: begin
            if (phase == PH_FRAME || cur.color == 4'd0) begin
              byte_now = CH_NINE;
            end else begin
              byte_now = COLOR_BASE + {4'd0, cur.color};
            end
          end
          default: byte_now = CH_M;
        endcase
        sec_last = (idx == 4'd4);
      end
      PH_CUR: begin
        if (idx == 4'd0) begin
          byte_now = CH_ESC;
        end else if (idx == 4'd1) begin
          byte_now = CH_LBRK;
        end else if (idx == semi_pos) begin
          byte_now = CH_SEMI;
        end else if (idx == col_end) begin
          byte_now = CH_H;
        end else begin
          byte_now = CH_ZERO | {4'd0, digit};
        end
        sec_last = (idx == col_end);
      end
      PH_TAIL: begin
        case (idx)
          4'd0:    byte_now = cur.tail[0];
          4'd1:    byte_now = cur.tail[1];
          default: byte_now = cur.tail[2];
        endcase
        sec_last = cur.tail3 ? (idx == 4'd2) : (idx == 4'd0);
      end
      default: ;
    endcase
  end

  // next section of the running command, and first section of a new one
  always_comb begin
    cmd_last    = 1'b0;
    phase_after = PH_TAIL;
    case (phase)
      PH_FRAME: begin
        if (cur.has_cur) begin
          phase_after = PH_CUR;
        end else if (cur.has_color) begin
          phase_after = PH_COLOR;
        end else if (cur.has_tail) begin
          phase_after = PH_TAIL;
        end else begin
          cmd_last = sec_last;
        end
      end
      PH_CUR: begin
        phase_after = cur.has_color ? PH_COLOR : PH_TAIL;
      end
      PH_COLOR: begin
        phase_after = PH_TAIL;
      end
      default: begin
        cmd_last = sec_last;
      end
    endcase
    if (q_cmd.has_frame) begin
      phase_first = PH_FRAME;
    end else if (q_cmd.has_cur) begin
      phase_first = PH_CUR;
    end else if (q_cmd.has_color) begin
      phase_first = PH_COLOR;
    end else begin
      phase_first = PH_TAIL;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      phase  <= PH_FRAME;
      idx    <= 4'd0;
      ovalid <= 1'b0;
    end else begin
      if (advance) begin
        ovalid   <= 1'b1;
        out_byte <= byte_now;
        run_last <= cmd_last;
      end else if (pop && ovalid) begin
        ovalid <= 1'b0;
      end
      if (q_rd) begin
        cur   <= q_cmd;
        busy  <= 1'b1;
        phase <= phase_first;
        idx   <= 4'd0;
      end else if (advance) begin
        if (sec_last) begin
          idx   <= 4'd0;
          phase <= phase_after;
        end else begin
          idx <= idx + 4'd1;
        end
        if (cmd_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
